>>> sv/assert_macros.svh
// concurrent assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/jsu_pkg.sv
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       input_end;
	} chr_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] fault_code;
		logic       last;
	} res_beat_t;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
	localparam logic [3:0] ERR_CONTROL    = 4'd2;
	localparam logic [3:0] ERR_ESCAPE     = 4'd3;
	localparam logic [3:0] ERR_HEX        = 4'd4;
	localparam logic [3:0] ERR_INCOMPLETE = 4'd5;
	localparam logic [3:0] ERR_NO_LOW     = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW    = 4'd7;
	localparam logic [3:0] ERR_LONE_LOW   = 4'd8;
	localparam logic [3:0] ERR_UNTERM     = 4'd9;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] HIGH_FIRST = 16'hd800;
	localparam logic [15:0] HIGH_LAST  = 16'hdbff;
	localparam logic [15:0] LOW_FIRST  = 16'hdc00;
	localparam logic [15:0] LOW_LAST   = 16'hdfff;

	localparam logic [20:0] CP_MAX1  = 21'h00007f;
	localparam logic [20:0] CP_MAX2  = 21'h0007ff;
	localparam logic [20:0] CP_MAX3  = 21'h00ffff;
	localparam logic [20:0] CP_PLANE = 21'h010000;

	localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF8_LEAD3 = 8'he0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	localparam int unsigned MAX_RES = 4;

endpackage

>>> sv/json_string_unescape_utf8_top.sv
// accepted byte is held in the input register, then is decoded into the result buffer:
// the first result is offered as soon as it is written into the result buffer
// one input byte per cycle while each yields at most one result and res_stall is low;
// a \u escape that expands to n utf-8 bytes holds the input side until its last byte is taken
// arst_n clears the parser to idle (awaiting an opening quote) and empties both registers
`include "assert_macros.svh"

module json_string_unescape_utf8_top
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      chr_valid,
	output logic      chr_stall,
	input  chr_beat_t chr_beat,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res_beat
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_STR,
		M_ESC,
		M_HEX1,
		M_NEED_BS,
		M_NEED_U,
		M_HEX2
	} mode_t;

	mode_t       mode_q, n_mode;
	logic [1:0]  hcnt_q, n_hcnt;
	logic [15:0] unit_q, n_unit;
	logic [9:0]  hoff_q, n_hoff;

	chr_beat_t   beat_s1;
	logic        valid_s1;

	res_beat_t   buf_q [MAX_RES];
	logic [2:0]  cnt_q;

	res_beat_t   r [MAX_RES];
	logic [2:0]  nres;

	logic        s1_move;
	logic        res_take;

	logic [7:0]  c;
	logic        e;
	logic [3:0]  hv;
	logic        hok;
	logic [15:0] unit_nx;
	logic [20:0] cp;
	logic        emit;

	assign res_take  = res_valid && !res_stall;
	assign res_valid = (cnt_q != 3'd0);
	assign res_beat  = buf_q[0];
	assign s1_move   = valid_s1 && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && !res_stall));
	assign chr_stall = valid_s1 && !s1_move;

	assign c = beat_s1.in_byte;
	assign e = beat_s1.input_end;

	// hex digit decode
	always_comb begin
		hok = 1'b1;
		hv  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hv = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hv = c[3:0] + 4'd9;
		end else begin
			hok = 1'b0;
		end
	end

	assign unit_nx = {unit_q[11:0], hv};

	always_comb begin
		n_mode = mode_q;
		n_hcnt = hcnt_q;
		n_unit = unit_q;
		n_hoff = hoff_q;
		nres   = 3'd0;
		cp     = 21'd0;
		emit   = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			r[i] = '{kind: KIND_DATA, out_byte: 8'd0, fault_code: ERR_NONE, last: 1'b0};
		end
		r[0].last = 1'b1;

		case (mode_q)
			M_IDLE: begin
				if (e || c != CH_QUOTE) begin
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_NO_QUOTE;
					nres = 3'd1;
				end else begin
					n_mode = M_STR;
				end
			end
			M_STR: begin
				nres = 3'd1;
				if (e) begin
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_UNTERM;
					n_mode = M_IDLE;
				end else if (c == CH_QUOTE) begin
					r[0].kind = KIND_DONE;
					n_mode = M_IDLE;
				end else if (c < CH_SPACE) begin
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_CONTROL;
					n_mode = M_IDLE;
				end else if (c == CH_BSL) begin
					nres = 3'd0;
					n_mode = M_ESC;
				end else begin
					r[0].out_byte = c;
				end
			end
			M_ESC: begin
				nres = 3'd1;
				n_mode = M_STR;
				if (e) begin
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_INCOMPLETE;
					n_mode = M_IDLE;
				end else begin
					case (c)
						CH_QUOTE, CH_BSL, CH_SLASH: r[0].out_byte = c;
						CH_B: r[0].out_byte = 8'h08;
						CH_F: r[0].out_byte = 8'h0c;
						CH_N: r[0].out_byte = 8'h0a;
						CH_R: r[0].out_byte = 8'h0d;
						CH_T: r[0].out_byte = 8'h09;
						CH_U: begin
							nres = 3'd0;
							n_mode = M_HEX1;
							n_hcnt = 2'd0;
							n_unit = 16'd0;
						end
						default: begin
							r[0].kind = KIND_ERR;
							r[0].fault_code = ERR_ESCAPE;
							n_mode = M_IDLE;
						end
					endcase
				end
			end
			M_HEX1, M_HEX2: begin
				if (e) begin
					nres = 3'd1;
					r[0].kind = KIND_ERR;
					r[0].fault_code = (mode_q == M_HEX1) ? ERR_INCOMPLETE : ERR_NO_LOW;
					n_mode = M_IDLE;
				end else if (!hok) begin
					nres = 3'd1;
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_HEX;
					n_mode = M_IDLE;
				end else if (hcnt_q != 2'd3) begin
					n_unit = unit_nx;
					n_hcnt = hcnt_q + 2'd1;
				end else if (mode_q == M_HEX1) begin
					n_hcnt = 2'd0;
					n_unit = 16'd0;
					if (unit_nx >= HIGH_FIRST && unit_nx <= HIGH_LAST) begin
						n_hoff = unit_nx[9:0];
						n_mode = M_NEED_BS;
					end else if (unit_nx >= LOW_FIRST && unit_nx <= LOW_LAST) begin
						nres = 3'd1;
						r[0].kind = KIND_ERR;
						r[0].fault_code = ERR_LONE_LOW;
						n_mode = M_IDLE;
					end else begin
						cp = {5'd0, unit_nx};
						emit = 1'b1;
						n_mode = M_STR;
					end
				end else begin
					n_hcnt = 2'd0;
					n_unit = 16'd0;
					if (unit_nx < LOW_FIRST || unit_nx > LOW_LAST) begin
						nres = 3'd1;
						r[0].kind = KIND_ERR;
						r[0].fault_code = ERR_BAD_LOW;
						n_mode = M_IDLE;
					end else begin
						// offsets concatenate: 0x10000 + (hi << 10) + lo
						cp = CP_PLANE + {1'b0, hoff_q, unit_nx[9:0]};
						emit = 1'b1;
						n_hoff = 10'd0;
						n_mode = M_STR;
					end
				end
			end
			M_NEED_BS, M_NEED_U: begin
				if (e || c != ((mode_q == M_NEED_BS) ? CH_BSL : CH_U)) begin
					nres = 3'd1;
					r[0].kind = KIND_ERR;
					r[0].fault_code = ERR_NO_LOW;
					n_mode = M_IDLE;
				end else if (mode_q == M_NEED_BS) begin
					n_mode = M_NEED_U;
				end else begin
					n_mode = M_HEX2;
					n_hcnt = 2'd0;
					n_unit = 16'd0;
				end
			end
			default: begin
				n_mode = M_IDLE;
			end
		endcase

		// utf-8 encode of a finished code point
		if (emit) begin
			r[0].last = 1'b0;
			if (cp <= CP_MAX1) begin
				nres = 3'd1;
				r[0].out_byte = cp[7:0];
				r[0].last = 1'b1;
			end else if (cp <= CP_MAX2) begin
				nres = 3'd2;
				r[0].out_byte = UTF8_LEAD2 | {3'd0, cp[10:6]};
				r[1].out_byte = UTF8_CONT | {2'd0, cp[5:0]};
				r[1].last = 1'b1;
			end else if (cp <= CP_MAX3) begin
				nres = 3'd3;
				r[0].out_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
				r[1].out_byte = UTF8_CONT | {2'd0, cp[11:6]};
				r[2].out_byte = UTF8_CONT | {2'd0, cp[5:0]};
				r[2].last = 1'b1;
			end else begin
				nres = 3'd4;
				r[0].out_byte = UTF8_LEAD4 | {5'd0, cp[20:18]};
				r[1].out_byte = UTF8_CONT | {2'd0, cp[17:12]};
				r[2].out_byte = UTF8_CONT | {2'd0, cp[11:6]};
				r[3].out_byte = UTF8_CONT | {2'd0, cp[5:0]};
				r[3].last = 1'b1;
			end
		end

		// every exit to idle clears the escape state
		if (n_mode == M_IDLE) begin
			n_hcnt = 2'd0;
			n_unit = 16'd0;
			n_hoff = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr_valid && !chr_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && !chr_stall) begin
			beat_s1 <= chr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hcnt_q <= 2'd0;
			unit_q <= 16'd0;
			hoff_q <= 10'd0;
		end else if (s1_move) begin
			mode_q <= n_mode;
			hcnt_q <= n_hcnt;
			unit_q <= n_unit;
			hoff_q <= n_hoff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (s1_move) begin
			cnt_q <= nres;
		end else if (res_take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// result buffer drains from entry 0
	always_ff @(posedge clk) begin
		if (s1_move) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_q[i] <= r[i];
			end
		end else if (res_take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	`JSU_ASSERT(a_cnt_range, 1'b1, cnt_q <= 3'd4, "result count out of range")
	`JSU_ASSERT(a_status_last, res_valid && res_beat.kind != KIND_DATA, res_beat.last,
		"completion or error beat not marked last")
	`JSU_ASSERT(a_last_count, res_valid && !res_beat.last, cnt_q > 3'd1,
		"non-final beat with nothing behind it")
	`JSU_ASSERT_NEXT(a_accept_holds, chr_valid && !chr_stall, valid_s1,
		"accepted byte lost from input register")

endmodule

>>> test/json_string_unescape_utf8_check.sv
module json_string_unescape_utf8_check
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      chr_valid,
	input  logic      chr_stall,
	input  chr_beat_t chr_beat,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_beat_t res_beat,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		PM_IDLE,
		PM_STRING,
		PM_ESCAPE,
		PM_HEX_HIGH,
		PM_WANT_BSL,
		PM_WANT_U,
		PM_HEX_LOW
	} parse_mode_t;

	// bytes that the single-letter escapes stand for
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0c;
	localparam logic [7:0] CTL_LF  = 8'h0a;
	localparam logic [7:0] CTL_CR  = 8'h0d;
	localparam logic [7:0] CTL_TAB = 8'h09;

	localparam int PRINT_CAP = 100;

	parse_mode_t mode = PM_IDLE;
	logic [1:0]  digits_seen = '0;
	logic [15:0] unit_acc = '0;
	logic [9:0]  high_part = '0;
	res_beat_t   decoded_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	function automatic void push_result(logic [1:0] k, logic [7:0] b, logic [3:0] e, logic l);
		res_beat_t r;
		r.kind = k;
		r.out_byte = b;
		r.fault_code = e;
		r.last = l;
		decoded_q = {decoded_q, r};
	endfunction

	function automatic void go_idle();
		mode = PM_IDLE;
		digits_seen = '0;
		unit_acc = '0;
		high_part = '0;
	endfunction

	function automatic void raise_error(logic [3:0] code);
		push_result(KIND_ERR, 8'h00, code, 1'b1);
		go_idle();
	endfunction

	function automatic void decode_char(chr_beat_t c);
		int          nib;
		logic [20:0] cp;
		logic        emit;
		nib = hex_nibble(c.in_byte);
		cp = '0;
		emit = 1'b0;
		case (mode)
			PM_IDLE: begin
				if (c.input_end || c.in_byte != CH_QUOTE) raise_error(ERR_NO_QUOTE);
				else mode = PM_STRING;
			end
			PM_STRING: begin
				if (c.input_end) raise_error(ERR_UNTERM);
				else if (c.in_byte == CH_QUOTE) begin
					push_result(KIND_DONE, 8'h00, ERR_NONE, 1'b1);
					go_idle();
				end else if (c.in_byte < CH_SPACE) raise_error(ERR_CONTROL);
				else if (c.in_byte == CH_BSL) mode = PM_ESCAPE;
				else push_result(KIND_DATA, c.in_byte, ERR_NONE, 1'b1);
			end
			PM_ESCAPE: begin
				if (c.input_end) raise_error(ERR_INCOMPLETE);
				else begin
					mode = PM_STRING;
					case (c.in_byte)
						CH_QUOTE, CH_BSL, CH_SLASH:
							push_result(KIND_DATA, c.in_byte, ERR_NONE, 1'b1);
						CH_B: push_result(KIND_DATA, CTL_BS, ERR_NONE, 1'b1);
						CH_F: push_result(KIND_DATA, CTL_FF, ERR_NONE, 1'b1);
						CH_N: push_result(KIND_DATA, CTL_LF, ERR_NONE, 1'b1);
						CH_R: push_result(KIND_DATA, CTL_CR, ERR_NONE, 1'b1);
						CH_T: push_result(KIND_DATA, CTL_TAB, ERR_NONE, 1'b1);
						CH_U: begin
							mode = PM_HEX_HIGH;
							digits_seen = '0;
							unit_acc = '0;
						end
						default: raise_error(ERR_ESCAPE);
					endcase
				end
			end
			PM_HEX_HIGH, PM_HEX_LOW: begin
				if (c.input_end) begin
					raise_error(mode == PM_HEX_HIGH ? ERR_INCOMPLETE : ERR_NO_LOW);
				end else if (nib < 0) raise_error(ERR_HEX);
				else begin
					unit_acc = {unit_acc[11:0], nib[3:0]};
					if (digits_seen != 2'd3) digits_seen++;
					else begin
						digits_seen = '0;
						if (mode == PM_HEX_HIGH) begin
							if (unit_acc >= HIGH_FIRST && unit_acc <= HIGH_LAST) begin
								// d800 has its low ten bits clear
								high_part = unit_acc[9:0];
								unit_acc = '0;
								mode = PM_WANT_BSL;
							end else if (unit_acc >= LOW_FIRST && unit_acc <= LOW_LAST) begin
								raise_error(ERR_LONE_LOW);
							end else begin
								cp = {5'b0, unit_acc};
								emit = 1'b1;
							end
						end else if (unit_acc < LOW_FIRST || unit_acc > LOW_LAST) begin
							raise_error(ERR_BAD_LOW);
						end else begin
							cp = CP_PLANE + {1'b0, high_part, unit_acc[9:0]};
							emit = 1'b1;
						end
					end
				end
				if (emit) begin
					unit_acc = '0;
					high_part = '0;
					mode = PM_STRING;
					if (cp <= CP_MAX1) begin
						push_result(KIND_DATA, cp[7:0], ERR_NONE, 1'b1);
					end else if (cp <= CP_MAX2) begin
						push_result(KIND_DATA, UTF8_LEAD2 | {3'b0, cp[10:6]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE, 1'b1);
					end else if (cp <= CP_MAX3) begin
						push_result(KIND_DATA, UTF8_LEAD3 | {4'b0, cp[15:12]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[11:6]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE, 1'b1);
					end else begin
						push_result(KIND_DATA, UTF8_LEAD4 | {5'b0, cp[20:18]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[17:12]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[11:6]}, ERR_NONE, 1'b0);
						push_result(KIND_DATA, UTF8_CONT | {2'b0, cp[5:0]}, ERR_NONE, 1'b1);
					end
				end
			end
			PM_WANT_BSL: begin
				if (c.input_end || c.in_byte != CH_BSL) raise_error(ERR_NO_LOW);
				else mode = PM_WANT_U;
			end
			PM_WANT_U: begin
				if (c.input_end || c.in_byte != CH_U) raise_error(ERR_NO_LOW);
				else begin
					mode = PM_HEX_LOW;
					digits_seen = '0;
					unit_acc = '0;
				end
			end
			default: go_idle();
		endcase
	endfunction

	task automatic report_mismatch(string what);
		if (fail_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic check_result(res_beat_t got);
		res_beat_t want;
		if (decoded_q.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing outstanding (kind %0d byte %h)",
				got.kind, got.out_byte));
		end else begin
			want = decoded_q.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
			if (got.fault_code !== want.fault_code)
				report_mismatch($sformatf("fault_code %0d, want %0d",
					got.fault_code, want.fault_code));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (chr_valid && !chr_stall) decode_char(chr_beat);
			if (res_valid && !res_stall) check_result(res_beat);
			pending = decoded_q.size();
		end
	end

endmodule

>>> test/json_string_unescape_utf8_top_tb.sv
module json_string_unescape_utf8_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jsu_pkg::*;

	localparam int RANDOM_ITEMS = 410;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      chr_valid;
	logic      chr_stall;
	chr_beat_t chr_beat;
	logic      res_valid;
	logic      res_stall;
	res_beat_t res_beat;

	int        fail_count;
	int        pending;
	bit        calm;
	bit        squeeze_req;
	int        sent_items;
	chr_beat_t text_q[$];

	json_string_unescape_utf8_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_beat  (chr_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

	json_string_unescape_utf8_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.chr_valid  (chr_valid),
		.chr_stall  (chr_stall),
		.chr_beat   (chr_beat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_beat   (res_beat),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void put_char(logic [7:0] b);
		chr_beat_t item;
		item.in_byte = b;
		item.input_end = 1'b0;
		text_q = {text_q, item};
	endfunction

	function automatic void put_end();
		chr_beat_t item;
		item.in_byte = 8'($urandom_range(0, 255));
		item.input_end = 1'b1;
		text_q = {text_q, item};
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return CH_ZERO + {4'd0, n};
		if ($urandom_range(0, 1)) return CH_LOWER_A + {4'd0, n} - 8'd10;
		return CH_UPPER_A + {4'd0, n} - 8'd10;
	endfunction

	function automatic void put_hex_digits(int count);
		for (int i = 0; i < count; i++) put_char(hex_char(4'($urandom_range(0, 15))));
	endfunction

	// backslash, u, then four digits in mixed case
	function automatic void put_unit(logic [15:0] v);
		put_char(CH_BSL);
		put_char(CH_U);
		for (int i = 3; i >= 0; i--) put_char(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UPPER_A && b <= CH_UPPER_F) ||
			(b >= CH_LOWER_A && b <= CH_LOWER_F));
		return b;
	endfunction

	// well-formed string content: plain bytes, short escapes, bmp units, pairs
	function automatic void put_body(int pieces);
		int         r;
		logic [7:0] b;
		logic [15:0] v;
		for (int i = 0; i < pieces; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				do b = 8'($urandom_range(CH_SPACE, 255));
				while (b == CH_QUOTE || b == CH_BSL);
				put_char(b);
			end else if (r < 60) begin
				put_char(CH_BSL);
				case ($urandom_range(0, 7))
					0: put_char(CH_QUOTE);
					1: put_char(CH_BSL);
					2: put_char(CH_SLASH);
					3: put_char(CH_B);
					4: put_char(CH_F);
					5: put_char(CH_N);
					6: put_char(CH_R);
					default: put_char(CH_T);
				endcase
			end else if (r < 82) begin
				case ($urandom_range(0, 3))
					0: v = 16'($urandom_range(0, 16'h007f));
					1: v = 16'($urandom_range(16'h0080, 16'h07ff));
					2: v = 16'($urandom_range(16'h0800, HIGH_FIRST - 1));
					default: v = 16'($urandom_range(LOW_LAST + 1, 16'hffff));
				endcase
				put_unit(v);
			end else begin
				put_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
				put_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
			end
		end
	endfunction

	// one string; most are well formed, the rest break somewhere along the way
	function automatic void make_sequence();
		int          pieces;
		int          flaw;
		logic [7:0]  b;
		logic [15:0] v;
		pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
		flaw = $urandom_range(0, 99) < 70 ? -1 : $urandom_range(0, 14);
		if (flaw == 0) begin
			do b = 8'($urandom_range(0, 255));
			while (b == CH_QUOTE);
			put_char(b);
		end else if (flaw == 1) begin
			put_end();
		end else begin
			put_char(CH_QUOTE);
			put_body(pieces);
			case (flaw)
				-1: put_char(CH_QUOTE);
				2: put_end();
				3: put_char(8'($urandom_range(0, CH_SPACE - 1)));
				4: begin
					put_char(CH_BSL);
					do b = 8'($urandom_range(0, 255));
					while (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_B ||
						b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
					put_char(b);
				end
				5: begin
					put_char(CH_BSL);
					put_end();
				end
				6, 7: begin
					put_char(CH_BSL);
					put_char(CH_U);
					put_hex_digits($urandom_range(0, 3));
					if (flaw == 6) put_end();
					else put_char(non_hex_byte());
				end
				8: put_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
				default: begin
					put_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
					case (flaw)
						9: begin
							do b = 8'($urandom_range(0, 255));
							while (b == CH_BSL);
							put_char(b);
						end
						10: begin
							put_char(CH_BSL);
							do b = 8'($urandom_range(0, 255));
							while (b == CH_U);
							put_char(b);
						end
						11: begin
							do v = 16'($urandom_range(0, 16'hffff));
							while (v >= LOW_FIRST && v <= LOW_LAST);
							put_unit(v);
						end
						12, 13: begin
							put_char(CH_BSL);
							put_char(CH_U);
							put_hex_digits($urandom_range(0, 3));
							if (flaw == 12) put_end();
							else put_char(non_hex_byte());
						end
						default: put_end();
					endcase
				end
			endcase
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_item(chr_beat_t item);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chr_beat <= item;
		chr_valid <= 1'b1;
		do @(posedge clk);
		while (chr_stall);
		@(negedge clk);
		sent_items++;
	endtask

	task automatic flush_text();
		while (text_q.size() > 0) send_item(text_q.pop_front());
	endtask

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : result_drain
		int run;
		run = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				// long hold-off so the block backs up and stalls its input
				res_stall <= 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
				squeeze_req = 1'b0;
				run = 0;
				res_stall <= 1'b0;
			end else if (run > 0) begin
				run--;
				if (run == 0) res_stall <= 1'b0;
			end else begin
				run = calm ? 0 : pick_gap();
				res_stall <= (run != 0);
			end
		end
	end

	initial begin : stimulus
		int start_items;
		arst_n = 1'b0;
		chr_valid = 1'b0;
		chr_beat = '0;
		res_stall = 1'b0;
		calm = 1'b1;
		squeeze_req = 1'b0;
		sent_items = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no opening quote, by end mark and by byte
		put_end();
		put_char(8'h00);
		// control character
		put_char(CH_QUOTE);
		put_char(8'h1f);
		// top byte passes, then an unknown escape letter
		put_char(CH_QUOTE);
		put_char(8'hff);
		put_char(CH_BSL);
		put_char(8'h78);
		// two-byte and four-byte sequences, highest code point
		put_char(CH_QUOTE);
		put_unit(16'h00e9);
		put_unit(HIGH_LAST);
		put_unit(LOW_LAST);
		put_char(CH_QUOTE);
		// bad hex digit
		put_char(CH_QUOTE);
		put_char(CH_BSL);
		put_char(CH_U);
		put_char(non_hex_byte());
		// end mark right after a backslash
		put_char(CH_QUOTE);
		put_char(CH_BSL);
		put_end();
		// low surrogate on its own
		put_char(CH_QUOTE);
		put_unit(LOW_FIRST);
		// high surrogate followed by a plain byte
		put_char(CH_QUOTE);
		put_unit(HIGH_FIRST);
		put_char(CH_LOWER_A);
		// high surrogate followed by a unit outside the low range
		put_char(CH_QUOTE);
		put_unit(HIGH_FIRST);
		put_unit(16'h0041);
		// end mark inside a string
		put_char(CH_QUOTE);
		put_end();
		flush_text();

		calm = 1'b0;
		squeeze_req = 1'b1;
		start_items = sent_items;
		while (sent_items - start_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) calm = !calm;
			make_sequence();
			flush_text();
		end
		chr_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/jsu_pkg.sv
sv/json_string_unescape_utf8_top.sv
test/json_string_unescape_utf8_check.sv
test/json_string_unescape_utf8_top_tb.sv
